// File: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Holds request, response and queue entry structs, codes and sequencer states.
// No dependencies.
package rau_pkg;

   localparam int WORD_BITS   = 64;
   localparam int DEN_BITS    = WORD_BITS - 1;
   localparam int WIDE_BITS   = 2 * WORD_BITS;
   localparam int HALF_BITS   = WORD_BITS / 2;
   localparam int SHIFT_BITS  = $clog2(WORD_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [WORD_BITS-1:0] MIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQ  = 3'd4,
      CMD_LT  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SIGN,
      S_COMB,
      S_NORM,
      S_GCD,
      S_DIV,
      S_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]                  cmd;
      logic signed [WORD_BITS-1:0] a_num;
      logic [DEN_BITS-1:0]         a_den;
      logic signed [WORD_BITS-1:0] b_num;
      logic [DEN_BITS-1:0]         b_den;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_num;
      logic [DEN_BITS-1:0]         res_den;
      logic                        compare_true;
      logic [1:0]                  status;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    known;
      logic    div0;
   } job_type;

endpackage

// File: src/rau_front.sv
// Front end of the rational arithmetic unit: accepts requests and classifies them.
// Flags unknown commands, zero denominators and zero divisors before queueing. Uses rau_pkg.
module rau_front (
   input  logic             req_valid,
   input  rau_pkg::req_type req_data,
   input  logic             q_full,
   output logic             req_stall,
   output logic             push,
   output rau_pkg::job_type job
);
   import rau_pkg::*;

   logic known;

   always_comb begin
      unique case (req_data.cmd)
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_LT: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      job.req   = req_data;
      job.known = known;
      job.div0  = known && ((req_data.a_den == '0) || (req_data.b_den == '0) ||
                  ((req_data.cmd == CMD_DIV) && (req_data.b_num == '0)));
   end

endmodule

// File: src/rau_queue.sv
// Short queue of classified requests between front and back end.
// Register based, QUEUE_DEPTH entries. Uses rau_pkg.
module rau_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rau_pkg::job_type push_job,
   input  logic             pop,
   output rau_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import rau_pkg::*;

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: src/rau_back.sv
// Back end of the rational arithmetic unit: sequencer with a shared 32x32
// multiplier, binary gcd and a restoring divider. Uses rau_pkg.
module rau_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  rau_pkg::job_type job,
   output logic             pop,
   output logic             res_valid,
   input  logic             res_take,
   output rau_pkg::rsp_type res
);
   import rau_pkg::*;

   state_type              state_ff, state_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [WORD_BITS-1:0]   amag_ff, amag_in, bmag_ff, bmag_in;
   logic [DEN_BITS-1:0]    ad_ff, ad_in, bd_ff, bd_in;
   logic                   asgn_ff, asgn_in, bsgn_ff, bsgn_in;
   logic [1:0]             pidx_ff, pidx_in, part_ff, part_in;
   logic [WIDE_BITS-1:0]   acc_ff, acc_in;
   logic [WIDE_BITS-1:0]   p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic                   nneg_ff, nneg_in;
   logic [WORD_BITS-1:0]   nm_ff, nm_in, dm_ff, dm_in;
   logic [WORD_BITS-1:0]   u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [SHIFT_BITS-1:0]  k_ff, k_in, cnt_ff, cnt_in;
   logic [WORD_BITS:0]     rem_ff, rem_in;
   logic [WORD_BITS-1:0]   q_ff, q_in, qn_ff, qn_in;
   logic                   phase_ff, phase_in;
   rsp_type                res_ff, res_in;

   // multiplier datapath
   logic [WORD_BITS-1:0]   xm, ym;
   logic [HALF_BITS-1:0]   xh, yh;
   logic [WORD_BITS-1:0]   pp;
   logic [WIDE_BITS-1:0]   pp_wide, acc_sum;
   logic                   s0, s1, s2;

   // normalize datapath
   logic [WORD_BITS-1:0]   nv, dv, nmag, dmag;
   logic                   nneg, dneg, fit_n, fit_d;

   // divider datapath
   logic [WORD_BITS:0]     rem_sh;
   logic                   ge;
   logic [WORD_BITS-1:0]   q_step;

   logic [WORD_BITS-1:0]   an_u, bn_u;

   assign res       = res_ff;
   assign pop       = (state_ff == S_IDLE) && job_valid;
   assign res_valid = (state_ff == S_OUT);

   always_comb begin
      unique case (pidx_ff)
         2'd0: begin
            xm = amag_ff;
            ym = (cmd_ff == CMD_MUL) ? bmag_ff : {1'b0, bd_ff};
         end
         2'd1: begin
            xm = bmag_ff;
            ym = {1'b0, ad_ff};
         end
         default: begin
            xm = {1'b0, ad_ff};
            ym = (cmd_ff == CMD_DIV) ? bmag_ff : {1'b0, bd_ff};
         end
      endcase
      xh = part_ff[1] ? xm[WORD_BITS-1:HALF_BITS] : xm[HALF_BITS-1:0];
      yh = part_ff[0] ? ym[WORD_BITS-1:HALF_BITS] : ym[HALF_BITS-1:0];
      pp = xh * yh;
      unique case (part_ff)
         2'd0:    pp_wide = {{WORD_BITS{1'b0}}, pp};
         2'd3:    pp_wide = {pp, {WORD_BITS{1'b0}}};
         default: pp_wide = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
      endcase
      acc_sum = ((part_ff == 2'd0) ? '0 : acc_ff) + pp_wide;
   end

   assign s0 = asgn_ff ^ ((cmd_ff == CMD_MUL) && bsgn_ff);
   assign s1 = bsgn_ff;
   assign s2 = (cmd_ff == CMD_DIV) && bsgn_ff;

   always_comb begin
      nv    = p0_ff[WORD_BITS-1:0];
      dv    = p2_ff[WORD_BITS-1:0];
      nneg  = nv[WORD_BITS-1];
      dneg  = dv[WORD_BITS-1];
      nmag  = nneg ? ('0 - nv) : nv;
      dmag  = dneg ? ('0 - dv) : dv;
      fit_n = (p0_ff[WIDE_BITS-1:WORD_BITS-1] == '0) || (p0_ff[WIDE_BITS-1:WORD_BITS-1] == '1);
      fit_d = (p2_ff[WIDE_BITS-1:WORD_BITS-1] == '0) || (p2_ff[WIDE_BITS-1:WORD_BITS-1] == '1);
   end

   always_comb begin
      rem_sh = {rem_ff[WORD_BITS-1:0], q_ff[WORD_BITS-1]};
      ge     = (rem_sh >= {1'b0, g_ff});
      q_step = {q_ff[WORD_BITS-2:0], ge};
   end

   assign an_u = job.req.a_num;
   assign bn_u = job.req.b_num;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               state_in = (!job.known || job.div0) ? S_OUT : S_MUL;
            end
         end
         S_MUL: begin
            if ((part_ff == 2'd3) && (pidx_ff == 2'd2)) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: state_in = S_COMB;
         S_COMB: begin
            state_in = ((cmd_ff == CMD_EQ) || (cmd_ff == CMD_LT)) ? S_OUT : S_NORM;
         end
         S_NORM: begin
            priority if (!fit_n || !fit_d) begin
               state_in = S_OUT;
            end else if (dneg && ((nneg && nmag == MIN_MAG) || dmag == MIN_MAG)) begin
               state_in = S_OUT;
            end else if (dmag == '0 || nmag == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (u_ff == '0) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (phase_ff && (cnt_ff == SHIFT_BITS'(WORD_BITS-1))) begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = S_OUT;
         S_OUT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      cmd_in   = cmd_ff;
      amag_in  = amag_ff;
      bmag_in  = bmag_ff;
      ad_in    = ad_ff;
      bd_in    = bd_ff;
      asgn_in  = asgn_ff;
      bsgn_in  = bsgn_ff;
      pidx_in  = pidx_ff;
      part_in  = part_ff;
      acc_in   = acc_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      nneg_in  = nneg_ff;
      nm_in    = nm_ff;
      dm_in    = dm_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      g_in     = g_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      qn_in    = qn_ff;
      phase_in = phase_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd_in  = job.req.cmd;
            asgn_in = an_u[WORD_BITS-1];
            bsgn_in = bn_u[WORD_BITS-1];
            amag_in = an_u[WORD_BITS-1] ? ('0 - an_u) : an_u;
            bmag_in = bn_u[WORD_BITS-1] ? ('0 - bn_u) : bn_u;
            ad_in   = job.req.a_den;
            bd_in   = job.req.b_den;
            pidx_in = '0;
            part_in = '0;
            res_in.res_num      = '0;
            res_in.res_den      = DEN_BITS'(1);
            res_in.compare_true = 1'b0;
            res_in.status       = job.div0 ? ST_DIV0 : ST_OK;
         end
         S_MUL: begin
            acc_in  = acc_sum;
            part_in = part_ff + 1'b1;
            if (part_ff == 2'd3) begin
               unique case (pidx_ff)
                  2'd0:    p0_in = acc_sum;
                  2'd1:    p1_in = acc_sum;
                  default: p2_in = acc_sum;
               endcase
               pidx_in = pidx_ff + 1'b1;
            end
         end
         S_SIGN: begin
            p0_in = s0 ? ('0 - p0_ff) : p0_ff;
            p1_in = s1 ? ('0 - p1_ff) : p1_ff;
            p2_in = s2 ? ('0 - p2_ff) : p2_ff;
         end
         S_COMB: begin
            unique case (cmd_ff)
               CMD_ADD: p0_in = p0_ff + p1_ff;
               CMD_SUB: p0_in = p0_ff - p1_ff;
               CMD_EQ:  res_in.compare_true = (p0_ff == p1_ff);
               CMD_LT:  res_in.compare_true = ($signed(p0_ff) < $signed(p1_ff));
               default: p0_in = p0_ff;
            endcase
         end
         S_NORM: begin
            nneg_in = nneg ^ dneg;
            nm_in   = nmag;
            dm_in   = dmag;
            u_in    = nmag;
            v_in    = dmag;
            k_in    = '0;
            priority if (!fit_n || !fit_d) begin
               res_in.status = ST_OVF;
            end else if (dneg && ((nneg && nmag == MIN_MAG) || dmag == MIN_MAG)) begin
               res_in.status = ST_OVF;
            end else if (dmag == '0) begin
               res_in.status = ST_DIV0;
            end
         end
         S_GCD: begin
            priority if (u_ff == '0) begin
               g_in     = v_ff << k_ff;
               rem_in   = '0;
               q_in     = nm_ff;
               cnt_in   = '0;
               phase_in = 1'b0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         S_DIV: begin
            rem_in = ge ? (rem_sh - {1'b0, g_ff}) : rem_sh;
            q_in   = q_step;
            cnt_in = cnt_ff + 1'b1;
            // switch from numerator to denominator after the last quotient bit
            if (!phase_ff && (cnt_ff == SHIFT_BITS'(WORD_BITS-1))) begin
               qn_in    = q_step;
               q_in     = dm_ff;
               rem_in   = '0;
               phase_in = 1'b1;
            end
         end
         S_FIN: begin
            res_in.res_num = nneg_ff ? ('0 - qn_ff) : qn_ff;
            res_in.res_den = q_ff[DEN_BITS-1:0];
         end
         S_OUT: res_in = res_ff;
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      amag_ff  <= amag_in;
      bmag_ff  <= bmag_in;
      ad_ff    <= ad_in;
      bd_ff    <= bd_in;
      asgn_ff  <= asgn_in;
      bsgn_ff  <= bsgn_in;
      pidx_ff  <= pidx_in;
      part_ff  <= part_in;
      acc_ff   <= acc_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      nneg_ff  <= nneg_in;
      nm_ff    <= nm_in;
      dm_ff    <= dm_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      qn_ff    <= qn_in;
      phase_ff <= phase_in;
      res_ff   <= res_in;
   end

endmodule

// File: src/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide and compare two
// reduced signed 64-bit rationals, one response per request. Requests enter a
// two-entry queue, registered there before the back end sees them, and are
// worked one at a time by a sequencer built around its shared 32x32 multiplier,
// binary gcd and restoring divider. A zero divisor, a zero denominator or an
// unknown command goes straight to the response. A comparison forms three cross
// products of four partial products each. An overflow or a zero numerator ends
// after normalization. Reduced arithmetic runs the binary gcd, then divides the
// numerator and the denominator by it one quotient bit a cycle.
// The output register lets the next request start while a response waits.
module rational_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   job_type front_job, head_job;
   logic    push, pop, q_full, q_empty;
   logic    res_valid, res_take;
   rsp_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   rau_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .push      (push),
      .job       (front_job)
   );

   rau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job       (head_job),
      .pop       (pop),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (res_valid && res_take) || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (res_valid && res_take) ? res : rsp_data_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.res_num == '0 && rsp_data.res_den == DEN_BITS'(1) && !rsp_data.compare_true))
      else $error("error response carries a value");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |->
      (rsp_data.status == ST_OK && rsp_data.res_num == '0 && rsp_data.res_den == DEN_BITS'(1)))
      else $error("comparison response carries a value");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("back end took from an empty queue");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.res_den != '0)
      else $error("zero denominator in response");

endmodule

// File: dv/rational_arith_unit_tb.sv
// Self-checking testbench for rational_arith_unit: drives rational requests,
// predicts each response with a local 128-bit model and compares in order.
// Depends on rau_pkg and the rational_arith_unit RTL.
`timescale 1ns / 1ps

module rational_arith_unit_tb;
   import rau_pkg::*;

   localparam int NUM_RANDOM    = 1100;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int LONG_HOLD_AT  = 3000;
   localparam int LONG_HOLD_LEN = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      fail_count;
   int      cycle_count;
   int      hold_off;
   int      drv_gap;
   int      rsp_wait;
   int      sent_count;
   int      in_count;
   int      n_items;

   rational_arith_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [127:0] ugcd(logic [127:0] x, logic [127:0] y);
      logic [127:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic bit fits_word(logic signed [127:0] v);
      return v >= -(128'sd1 <<< 63) && v <= ((128'sd1 <<< 63) - 1);
   endfunction

   // Exact rational result using 128-bit signed arithmetic.
   function automatic rsp_type rational_result(req_type r);
      rsp_type             o;
      logic signed [127:0] an, ad, bn, bd, num, den, nm, dm, g;
      bit                  nneg;
      o = '0;
      o.res_den = 63'd1;
      o.status = ST_OK;
      an = r.a_num;
      bn = r.b_num;
      ad = $signed({65'd0, r.a_den});
      bd = $signed({65'd0, r.b_den});
      if (r.cmd > CMD_LT) return o;
      if (ad == 0 || bd == 0 || (r.cmd == CMD_DIV && bn == 0)) begin
         o.status = ST_DIV0;
         return o;
      end
      case (r.cmd)
         CMD_EQ: begin
            o.compare_true = (an * bd) == (bn * ad);
            return o;
         end
         CMD_LT: begin
            o.compare_true = (an * bd) < (bn * ad);
            return o;
         end
         CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
         CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
         CMD_MUL: begin num = an * bn; den = ad * bd; end
         default: begin num = an * bd; den = ad * bn; end
      endcase
      if (!fits_word(num) || !fits_word(den)) begin
         o.status = ST_OVF;
         return o;
      end
      nneg = num < 0;
      nm = nneg ? -num : num;
      dm = den < 0 ? -den : den;
      if (den < 0) begin
         if ((nneg && nm == (128'sd1 <<< 63)) || dm == (128'sd1 <<< 63)) begin
            o.status = ST_OVF;
            return o;
         end
         nneg = !nneg;
      end
      if (nm == 0) return o;
      g = ugcd(nm, dm);
      nm = nm / g;
      dm = dm / g;
      o.res_num = nneg ? -nm[63:0] : nm[63:0];
      o.res_den = dm[62:0];
      return o;
   endfunction

   function automatic logic [63:0] pick_num();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7FFF_FFFF_FFFF_FFFF;
         2: return 64'($signed($urandom_range(0, 40)) - 20);
         3: return {$urandom, $urandom};
         4: return 64'($signed($urandom) >>> $urandom_range(0, 31));
         default: return 64'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic logic [62:0] pick_den();
      case ($urandom_range(0, 5))
         0: return 63'h7FFF_FFFF_FFFF_FFFF;
         1: return 63'(1);
         2: return 63'({$urandom, $urandom} >> 1);
         3: return 63'($urandom >> $urandom_range(0, 31));
         4: return 63'(0);
         default: return 63'($urandom_range(1, 100));
      endcase
   endfunction

   task automatic add_req(logic [2:0] c, logic [63:0] an, logic [62:0] ad,
                          logic [63:0] bn, logic [62:0] bd);
      req_type r;
      r.cmd = c;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      pending_reqs.push_back(r);
   endtask

   // Driver: hold a stalled request, else idle for the drawn gap, else send next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         drv_gap   <= $urandom_range(0, 5);
      end else if (req_valid && in_count != sent_count) begin
         req_valid <= 1'b1;
      end else if (drv_gap > 0) begin
         req_valid <= 1'b0;
         drv_gap   <= drv_gap - 1;
      end else if (pending_reqs.size() != 0) begin
         req_valid  <= 1'b1;
         req_data   <= pending_reqs.pop_front();
         sent_count <= sent_count + 1;
         drv_gap    <= $urandom_range(0, 5);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Input monitor: predict each accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(rational_result(req_data));
         in_count <= in_count + 1;
      end
   end

   // Long hold-off window, counted on its own.
   always @(negedge clock) begin
      if (reset) begin
         hold_off <= 0;
      end else if (cycle_count == LONG_HOLD_AT) begin
         hold_off <= LONG_HOLD_LEN;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // Receiver: stall each response for a randomly drawn wait.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= $urandom_range(0, 5);
      end else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid) rsp_wait <= $urandom_range(0, 5);
      end
   end

   // Monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            fail_count <= fail_count + 1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.res_num !== e.res_num || rsp_data.res_den !== e.res_den ||
                rsp_data.compare_true !== e.compare_true ||
                rsp_data.status !== e.status) begin
               $display("%0t: mismatch expected num=%0d den=%0d cmp=%0b st=%0d",
                        $time, e.res_num, e.res_den, e.compare_true, e.status);
               $display("%0t:          actual   num=%0d den=%0d cmp=%0b st=%0d",
                        $time, rsp_data.res_num, rsp_data.res_den,
                        rsp_data.compare_true, rsp_data.status);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [63:0] mn;
      logic [62:0] md;
      reset = 1'b1;
      mn = 64'h8000_0000_0000_0000;
      md = 63'h7FFF_FFFF_FFFF_FFFF;
      // Directed: every operation, extremes, zero divisor, zero denominators,
      // minimum numerator, sign-move overflow and unknown commands.
      add_req(CMD_ADD, 1, 2, 1, 3);
      add_req(CMD_SUB, 1, 2, 1, 2);
      add_req(CMD_MUL, -3, 4, 2, 9);
      add_req(CMD_DIV, 3, 4, -9, 8);
      add_req(CMD_DIV, 3, 4, 0, 1);
      add_req(CMD_EQ, 2, 4, 1, 2);
      add_req(CMD_LT, -1, 2, 1, 3);
      add_req(CMD_LT, 1, 3, -1, 2);
      add_req(CMD_ADD, 1, 0, 1, 1);
      add_req(CMD_EQ, 1, 1, 1, 0);
      add_req(CMD_MUL, mn, 1, 1, 1);
      add_req(CMD_DIV, 1, 1, mn, 1);
      add_req(CMD_DIV, mn, 1, -1, 1);
      add_req(CMD_MUL, mn, 1, -1, 1);
      add_req(CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1);
      add_req(CMD_MUL, 1, md, 1, md);
      add_req(CMD_SUB, mn, md, 64'h7FFF_FFFF_FFFF_FFFF, md);
      add_req(CMD_LT, mn, 1, 64'h7FFF_FFFF_FFFF_FFFF, md);
      add_req(CMD_EQ, mn, md, mn, md);
      add_req(3'd6, 5, 7, 1, 1);
      add_req(3'd7, 0, 0, 0, 0);
      add_req(CMD_ADD, 0, 5, 0, 7);
      add_req(CMD_DIV, -1, md, -1, 1);
      for (int i = 0; i < NUM_RANDOM; i++)
         add_req($urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) :
                 3'($urandom_range(0, 5)),
                 pick_num(), pick_den(), pick_num(), pick_den());
      n_items = pending_reqs.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (in_count == n_items && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
